FILE: rtl/embedded_signature_scanner_assert.svh
// Assertion macros shared by the scanner RTL.
// ESS_ASSERT checks a property on every rising clock edge outside reset.
// ESS_ASSERT_NEVER checks that a condition is never true outside reset.
`ifndef EMBEDDED_SIGNATURE_SCANNER_ASSERT_SVH
`define EMBEDDED_SIGNATURE_SCANNER_ASSERT_SVH
`ifndef ASSERT_OFF
`define ESS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define ESS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ESS_ASSERT(lbl, clk, rst_n, prop)
`define ESS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/ess_pkg.sv
`default_nettype none

package ess_pkg;

    localparam int NUM_SIGS         = 24;
    localparam int SIG_MAX          = 8;
    localparam int SIG_ID_W         = 5;
    localparam int HIT_OFFSET_W     = 32;
    localparam int TOTAL_W          = 8;
    localparam int CAP_W            = 4;
    localparam int CFG_INDEX_W      = 4;
    localparam int CFG_DATA_W       = 4;
    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int WINDOW_LEN_DEF   = 8;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result beat payload: id, offset, cap flag, total, padded to bytes.
    localparam int FIELDS_W = SIG_ID_W + HIT_OFFSET_W + 1 + TOTAL_W;
    localparam int DATA_W   = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = DATA_W - FIELDS_W;

    localparam logic [CFG_INDEX_W-1:0] REG_HIT_CAP    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_OFFSET = 4'd1;

    localparam logic [CAP_W-1:0] HIT_CAP_RST    = 4'd8;
    localparam logic [CAP_W-1:0] MIN_OFFSET_RST = 4'd1;

    localparam logic KIND_HIT     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 8'hff;

    typedef logic [7:0] sig_row_t [SIG_MAX];

    localparam sig_row_t SIG_BYTES [NUM_SIGS] = '{
        '{8'h7f, 8'h45, 8'h4c, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a},
        '{8'hff, 8'hd8, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4d, 8'h4d, 8'h00, 8'h2a, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4b, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1f, 8'h8b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h5a, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hfd, 8'h37, 8'h7a, 8'h58, 8'h5a, 8'h00, 8'h00, 8'h00},
        '{8'h28, 8'hb5, 8'h2f, 8'hfd, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h04, 8'h22, 8'h4d, 8'h18, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h37, 8'h7a, 8'hbc, 8'haf, 8'h27, 8'h1c, 8'h00, 8'h00},
        '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1a, 8'h07, 8'h01, 8'h00},
        '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1a, 8'h07, 8'h00, 8'h00},
        '{8'hcf, 8'hfa, 8'hed, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hce, 8'hfa, 8'hed, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h61, 8'h73, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4f, 8'h67, 8'h67, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h4c, 8'h61, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1a, 8'h45, 8'hdf, 8'ha3, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h51, 8'h4c, 8'h69, 8'h74, 8'h65, 8'h20, 8'h66}
    };

    localparam int SIG_LEN [NUM_SIGS] = '{
        4, 8, 3, 4, 4, 4, 4, 4, 2, 3, 6, 4, 4, 6, 8, 7, 4, 4, 4, 4, 4, 3, 4, 8
    };

    typedef struct packed {
        logic [CAP_W-1:0] hit_cap;
        logic [CAP_W-1:0] min_offset;
    } cfg_t;

    typedef struct packed {
        logic                    hit_valid;
        logic [SIG_ID_W-1:0]     sig_id;
        logic [HIT_OFFSET_W-1:0] hit_offset;
        logic                    cap_reached;
        logic                    sum_valid;
        logic [TOTAL_W-1:0]      total;
    } q_entry_t;

endpackage

`default_nettype wire

FILE: rtl/ess_front.sv
`default_nettype none

module ess_front #(
    parameter int OFFSET_WIDTH = ess_pkg::OFFSET_WIDTH_DEF,
    parameter int WINDOW_LEN   = ess_pkg::WINDOW_LEN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_eob,
    input  wire ess_pkg::cfg_t     cfg,
    input  wire logic              q_full,
    output logic                   push,
    output ess_pkg::q_entry_t      push_entry
);

    localparam int HIST_LEN = WINDOW_LEN;
    localparam int WIN_LEN  = WINDOW_LEN - 1;
    localparam int THR_W    = 5;

    logic [7:0]              win_reg [WIN_LEN];
    logic [OFFSET_WIDTH-1:0] pos_reg;

    logic                    s1_valid_reg;
    logic                    s1_hit_reg;
    logic [ess_pkg::SIG_ID_W-1:0] s1_id_reg;
    logic [OFFSET_WIDTH-1:0] s1_start_reg;
    logic                    s1_eob_reg;

    logic [ess_pkg::CAP_W-1:0]   cnt_reg [ess_pkg::NUM_SIGS];
    logic [ess_pkg::TOTAL_W-1:0] total_reg;

    logic [7:0]              hist [HIST_LEN];
    logic [ess_pkg::NUM_SIGS-1:0] lane_hit;
    logic                    any_hit;
    logic [ess_pkg::SIG_ID_W-1:0] hit_id;
    logic [2:0]              hit_len_m1;
    logic [OFFSET_WIDTH-1:0] hit_start;
    logic                    accept;
    logic                    advance;

    logic [ess_pkg::CAP_W-1:0]   cnt_sel;
    logic [ess_pkg::CAP_W-1:0]   cnt_inc;
    logic                        eligible;
    logic [ess_pkg::TOTAL_W-1:0] total_new;
    logic [OFFSET_WIDTH+ess_pkg::HIT_OFFSET_W-1:0] start_ext;

    assign advance  = s1_valid_reg && !q_full;
    assign in_ready = !s1_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            hist[i] = win_reg[i];
        end
        hist[HIST_LEN-1] = in_byte;
    end

    // Each lane compares its signature against the newest bytes. A lane only
    // fires once the blob holds the whole signature and the start offset is
    // at or above min_offset: pos >= len - 1 + min_offset.
    always_comb begin
        logic [THR_W-1:0] thr;
        logic             pos_ok;
        int               idx;
        for (int s = 0; s < ess_pkg::NUM_SIGS; s++) begin
            thr = THR_W'(ess_pkg::SIG_LEN[s] - 1) + THR_W'(cfg.min_offset);
            pos_ok = (|pos_reg[OFFSET_WIDTH-1:THR_W]) || (pos_reg[THR_W-1:0] >= thr);
            lane_hit[s] = pos_ok;
            for (int k = 0; k < ess_pkg::SIG_MAX; k++) begin
                idx = (k < ess_pkg::SIG_LEN[s]) ? (HIST_LEN - ess_pkg::SIG_LEN[s] + k) : 0;
                if (k < ess_pkg::SIG_LEN[s]) begin
                    if (hist[idx] != ess_pkg::SIG_BYTES[s][k]) begin
                        lane_hit[s] = 1'b0;
                    end
                end
            end
        end
    end

    // Lowest matching lane wins; no signature is a suffix of another, so at
    // most one lane fires anyway.
    always_comb begin
        any_hit    = |lane_hit;
        hit_id     = '0;
        hit_len_m1 = '0;
        for (int s = ess_pkg::NUM_SIGS - 1; s >= 0; s--) begin
            if (lane_hit[s]) begin
                hit_id     = ess_pkg::SIG_ID_W'(s);
                hit_len_m1 = 3'(ess_pkg::SIG_LEN[s] - 1);
            end
        end
        hit_start = pos_reg - OFFSET_WIDTH'(hit_len_m1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            for (int i = 0; i < WIN_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else if (accept) begin
            if (in_eob) begin
                pos_reg <= '0;
                for (int i = 0; i < WIN_LEN; i++) begin
                    win_reg[i] <= '0;
                end
            end else begin
                pos_reg <= pos_reg + OFFSET_WIDTH'(1);
                for (int i = 0; i < WIN_LEN - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WIN_LEN-1] <= in_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_hit_reg   <= any_hit;
            s1_id_reg    <= hit_id;
            s1_start_reg <= hit_start;
            s1_eob_reg   <= in_eob;
        end
    end

    // Second step: apply the per-signature cap and keep the counts.
    assign cnt_sel   = cnt_reg[s1_id_reg];
    assign cnt_inc   = cnt_sel + ess_pkg::CAP_W'(1);
    assign eligible  = s1_hit_reg && (cnt_sel < cfg.hit_cap);
    assign total_new = (eligible && (total_reg != ess_pkg::TOTAL_MAX))
                       ? total_reg + ess_pkg::TOTAL_W'(1) : total_reg;
    assign start_ext = {ess_pkg::HIT_OFFSET_W'(0), s1_start_reg};

    assign push = advance && (eligible || s1_eob_reg);

    always_comb begin
        push_entry.hit_valid   = eligible;
        push_entry.sig_id      = s1_id_reg;
        push_entry.hit_offset  = start_ext[ess_pkg::HIT_OFFSET_W-1:0];
        push_entry.cap_reached = (cnt_inc == cfg.hit_cap);
        push_entry.sum_valid   = s1_eob_reg;
        push_entry.total       = total_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            for (int s = 0; s < ess_pkg::NUM_SIGS; s++) begin
                cnt_reg[s] <= '0;
            end
        end else if (advance) begin
            if (s1_eob_reg) begin
                total_reg <= '0;
                for (int s = 0; s < ess_pkg::NUM_SIGS; s++) begin
                    cnt_reg[s] <= '0;
                end
            end else if (eligible) begin
                total_reg <= total_new;
                cnt_reg[s1_id_reg] <= cnt_inc;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ess_queue.sv
`default_nettype none

`include "embedded_signature_scanner_assert.svh"

module ess_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire ess_pkg::q_entry_t push_entry,
    input  wire logic              pop,
    output logic                   full,
    output logic                   empty,
    output ess_pkg::q_entry_t      head
);

    localparam int DEPTH = ess_pkg::QUEUE_DEPTH;

    ess_pkg::q_entry_t mem_reg [DEPTH];
    logic [ess_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [ess_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [ess_pkg::QUEUE_CNT_W-1:0] count_reg;

    assign full  = (count_reg == ess_pkg::QUEUE_CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == ess_pkg::QUEUE_PTR_W'(DEPTH - 1))
                              ? '0 : wr_ptr_reg + ess_pkg::QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == ess_pkg::QUEUE_PTR_W'(DEPTH - 1))
                              ? '0 : rd_ptr_reg + ess_pkg::QUEUE_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + ess_pkg::QUEUE_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - ess_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

    `ESS_ASSERT_NEVER(a_push_full, aclk, aresetn, push && full)
    `ESS_ASSERT_NEVER(a_pop_empty, aclk, aresetn, pop && empty)
    `ESS_ASSERT(a_count_range, aclk, aresetn, count_reg <= ess_pkg::QUEUE_CNT_W'(DEPTH))

endmodule

`default_nettype wire

FILE: rtl/ess_back.sv
`default_nettype none

`include "embedded_signature_scanner_assert.svh"

module ess_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_empty,
    input  wire ess_pkg::q_entry_t           q_head,
    output logic                             pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [ess_pkg::DATA_W-1:0]       m_data,
    output logic                             m_kind,
    output logic                             m_last
);

    logic                            m_valid_reg, m_valid_next;
    logic                            pend_reg, pend_next;
    logic [ess_pkg::TOTAL_W-1:0]     pend_total_reg, pend_total_next;
    logic                            out_kind_reg, out_kind_next;
    logic [ess_pkg::SIG_ID_W-1:0]    out_id_reg, out_id_next;
    logic [ess_pkg::HIT_OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic                            out_cap_reg, out_cap_next;
    logic [ess_pkg::TOTAL_W-1:0]     out_total_reg, out_total_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = out_free && !pend_reg && !q_empty;

    // An entry that holds a hit and a summary leaves as two beats; the
    // summary waits in the pending register behind the hit.
    always_comb begin
        m_valid_next    = m_valid_reg;
        pend_next       = pend_reg;
        pend_total_next = pend_total_reg;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_offset_next = out_offset_reg;
        out_cap_next    = out_cap_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        if (out_free) begin
            if (pend_reg) begin
                m_valid_next    = 1'b1;
                pend_next       = 1'b0;
                out_kind_next   = ess_pkg::KIND_SUMMARY;
                out_id_next     = '0;
                out_offset_next = '0;
                out_cap_next    = 1'b0;
                out_total_next  = pend_total_reg;
                out_last_next   = 1'b1;
            end else if (!q_empty) begin
                m_valid_next = 1'b1;
                if (q_head.hit_valid) begin
                    out_kind_next   = ess_pkg::KIND_HIT;
                    out_id_next     = q_head.sig_id;
                    out_offset_next = q_head.hit_offset;
                    out_cap_next    = q_head.cap_reached;
                    out_total_next  = '0;
                    out_last_next   = !q_head.sum_valid;
                    pend_next       = q_head.sum_valid;
                    pend_total_next = q_head.total;
                end else begin
                    out_kind_next   = ess_pkg::KIND_SUMMARY;
                    out_id_next     = '0;
                    out_offset_next = '0;
                    out_cap_next    = 1'b0;
                    out_total_next  = q_head.total;
                    out_last_next   = 1'b1;
                end
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_total_reg <= pend_total_next;
        out_kind_reg   <= out_kind_next;
        out_id_reg     <= out_id_next;
        out_offset_reg <= out_offset_next;
        out_cap_reg    <= out_cap_next;
        out_total_reg  <= out_total_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = out_kind_reg;
    assign m_last  = out_last_reg;
    assign m_data  = {ess_pkg::PAD_W'(0), out_total_reg, out_cap_reg,
                      out_offset_reg, out_id_reg};

    `ESS_ASSERT(a_pend_behind_hit, aclk, aresetn, pend_reg |-> (m_valid_reg && !out_last_reg && (out_kind_reg == ess_pkg::KIND_HIT)))
    `ESS_ASSERT_NEVER(a_pop_while_pend, aclk, aresetn, pop && pend_reg)
    `ESS_ASSERT(a_summary_last, aclk, aresetn, (m_valid_reg && (out_kind_reg == ess_pkg::KIND_SUMMARY)) |-> out_last_reg)

endmodule

`default_nettype wire

FILE: rtl/embedded_signature_scanner.sv
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid/s_tready   s_tdata[7:0] data_byte, s_tlast end_of_blob
// m_       out  m_tvalid/m_tready   m_tdata id/offset/cap/total, m_tuser result_kind,
//                                   m_tlast last_of_run
// cfg_     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// One byte is accepted every cycle while the queue has room; all 24 signatures
// are compared in parallel. Result beats leave at one per cycle while m_tready
// is high; a blob's final byte with a hit makes two. A byte's result passes the
// scan register, the queue, which absorbs short stalls, and the output register.
// Reset is synchronous and needs no clearing pass; cfg_ready is always high.
`default_nettype none

module embedded_signature_scanner #(
    parameter int OFFSET_WIDTH = ess_pkg::OFFSET_WIDTH_DEF,
    parameter int WINDOW_LEN   = ess_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // data_byte
    input  wire logic                             s_tlast,   // end_of_blob
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // signature_id [4:0], hit_offset [36:5], cap_reached [37], total_hits [45:38]
    output logic [ess_pkg::DATA_W-1:0]            m_tdata,
    output logic                                  m_tuser,   // result_kind
    output logic                                  m_tlast,   // last_of_run
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ess_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ess_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [ess_pkg::CAP_W-1:0] hit_cap_reg, hit_cap_next;
    logic [ess_pkg::CAP_W-1:0] min_offset_reg, min_offset_next;
    ess_pkg::cfg_t             cfg;

    logic              q_full;
    logic              q_empty;
    logic              push;
    logic              pop;
    ess_pkg::q_entry_t push_entry;
    ess_pkg::q_entry_t q_head;

    assign cfg_ready = 1'b1;

    always_comb begin
        hit_cap_next    = hit_cap_reg;
        min_offset_next = min_offset_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                ess_pkg::REG_HIT_CAP:    hit_cap_next    = cfg_data;
                ess_pkg::REG_MIN_OFFSET: min_offset_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cap_reg    <= ess_pkg::HIT_CAP_RST;
            min_offset_reg <= ess_pkg::MIN_OFFSET_RST;
        end else begin
            hit_cap_reg    <= hit_cap_next;
            min_offset_reg <= min_offset_next;
        end
    end

    assign cfg.hit_cap    = hit_cap_reg;
    assign cfg.min_offset = min_offset_reg;

    ess_front #(
        .OFFSET_WIDTH(OFFSET_WIDTH),
        .WINDOW_LEN  (WINDOW_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_eob    (s_tlast),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_entry(push_entry)
    );

    ess_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    ess_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .q_head (q_head),
        .pop    (pop),
        .m_valid(m_tvalid),
        .m_ready(m_tready),
        .m_data (m_tdata),
        .m_kind (m_tuser),
        .m_last (m_tlast)
    );

endmodule

`default_nettype wire

FILE: sim/embedded_signature_scanner_test.sv
module embedded_signature_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int ITEM_GOAL    = 1950;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 300;

    localparam logic [ess_pkg::CFG_INDEX_W-1:0] REG_UNUSED_FIRST =
        ess_pkg::CFG_INDEX_W'(ess_pkg::REG_MIN_OFFSET + 1);
    localparam logic [ess_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LAST  = '1;

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic        kind;
        logic [4:0]  id;
        logic [31:0] offset;
        logic        cap;
        logic [7:0]  total;
        logic        last;
    } scan_result_t;

    // Predicts the hit and summary beats of the scanner and checks the
    // beats that leave it, in order.
    class hit_scoreboard;
        logic [63:0]  sig_pat [ess_pkg::NUM_SIGS];
        int           sig_len [ess_pkg::NUM_SIGS];
        logic [3:0]   hit_cap;
        logic [3:0]   min_offset;
        logic [7:0]   window [7];
        logic [31:0]  position;
        logic [3:0]   sig_hits [ess_pkg::NUM_SIGS];
        logic [7:0]   total;
        scan_result_t expected_results [$];
        int           errors;

        function new();
            // Signature bytes, first byte in the top bits.
            sig_pat = '{
                64'h7f454c46_00000000, 64'h89504e47_0d0a1a0a, 64'hffd8ff00_00000000,
                64'h47494638_00000000, 64'h49492a00_00000000, 64'h4d4d002a_00000000,
                64'h25504446_00000000, 64'h504b0304_00000000, 64'h1f8b0000_00000000,
                64'h425a6800_00000000, 64'hfd377a58_5a000000, 64'h28b52ffd_00000000,
                64'h04224d18_00000000, 64'h377abcaf_271c0000, 64'h52617221_1a070100,
                64'h52617221_1a070000, 64'hcffaedfe_00000000, 64'hcefaedfe_00000000,
                64'h0061736d_00000000, 64'h4f676753_00000000, 64'h664c6143_00000000,
                64'h49443300_00000000, 64'h1a45dfa3_00000000, 64'h53514c69_74652066
            };
            sig_len = '{4, 8, 3, 4, 4, 4, 4, 4, 2, 3, 6, 4, 4, 6, 8, 7, 4, 4, 4, 4, 4, 3, 4, 8};
            hit_cap    = 4'd8;
            min_offset = 4'd1;
            errors     = 0;
            clear_blob();
        endfunction

        function void clear_blob();
            foreach (window[i]) window[i] = 8'h00;
            foreach (sig_hits[i]) sig_hits[i] = 4'd0;
            position = '0;
            total    = '0;
        endfunction

        function void write_register(logic [3:0] index, logic [3:0] value);
            if (index == ess_pkg::REG_HIT_CAP)
                hit_cap = value;
            else if (index == ess_pkg::REG_MIN_OFFSET)
                min_offset = value;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void note_byte(logic [7:0] data, logic last);
            logic [7:0]   hist [8];
            logic [31:0]  start;
            scan_result_t res;
            bit           match;
            bit           emitted;
            int           len;
            emitted = 0;
            for (int i = 0; i < 7; i++) hist[i] = window[i];
            hist[7] = data;
            for (int s = 0; s < ess_pkg::NUM_SIGS; s++) begin
                len = sig_len[s];
                // A signature needs all its bytes inside the current blob.
                match = !emitted && (position >= 32'(len - 1));
                for (int k = 0; k < len; k++)
                    if (hist[8 - len + k] != sig_pat[s][63 - 8 * k -: 8]) match = 0;
                if (match) begin
                    start = position - 32'(len - 1);
                    if (start >= 32'(min_offset) && sig_hits[s] < hit_cap) begin
                        sig_hits[s]++;
                        if (total != 8'hff) total++;
                        res.kind   = ess_pkg::KIND_HIT;
                        res.id     = 5'(s);
                        res.offset = start;
                        res.cap    = (sig_hits[s] == hit_cap);
                        res.total  = '0;
                        res.last   = !last;
                        expected_results.push_back(res);
                        emitted = 1;
                    end
                end
            end
            if (last) begin
                res.kind   = ess_pkg::KIND_SUMMARY;
                res.id     = '0;
                res.offset = '0;
                res.cap    = 1'b0;
                res.total  = total;
                res.last   = 1'b1;
                expected_results.push_back(res);
                clear_blob();
            end else begin
                for (int i = 0; i < 6; i++) window[i] = window[i + 1];
                window[6] = data;
                position++;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(scan_result_t got);
            scan_result_t want;
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: kind %0d id %0d offset %0h",
                       got.kind, got.id, got.offset);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("result_kind", 32'(want.kind), 32'(got.kind));
            compare_field("signature_id", 32'(want.id), 32'(got.id));
            compare_field("hit_offset", want.offset, got.offset);
            compare_field("cap_reached", 32'(want.cap), 32'(got.cap));
            compare_field("total_hits", 32'(want.total), 32'(got.total));
            compare_field("last_of_run", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [ess_pkg::DATA_W-1:0]      m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ess_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ess_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    hit_scoreboard sb;
    int            items_sent  = 0;
    int            hold_cycles = 0;
    int            cycle_count = 0;
    bit            rx_fast     = 0;

    embedded_signature_scanner u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // data_byte
        .s_tlast   (s_tlast),   // end_of_blob
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // signature_id, hit_offset, cap_reached, total_hits
        .m_tuser   (m_tuser),   // result_kind
        .m_tlast   (m_tlast),   // last_of_run
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic int draw_gap(bit no_idle);
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [3:0] pick_setting();
        int roll;
        roll = $urandom_range(0, 5);
        if (roll == 0) return 4'd0;
        if (roll == 1) return 4'd15;
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic void append_sig(ref byte_q_t q, input int s, input int count);
        for (int k = 0; k < count; k++) q.push_back(sb.sig_pat[s][63 - 8 * k -: 8]);
    endfunction

    // Mostly whole signatures with random content around them; some
    // truncated or corrupted ones and plain noise.
    function automatic void build_blob(ref byte_q_t q, input int target, input bit noise);
        int s;
        int roll;
        int at;
        q.delete();
        while (q.size() < target) begin
            roll = noise ? 99 : $urandom_range(0, 99);
            s = $urandom_range(0, ess_pkg::NUM_SIGS - 1);
            if (roll < 62) begin
                append_sig(q, s, sb.sig_len[s]);
            end else if (roll < 77) begin
                append_sig(q, s, $urandom_range(1, sb.sig_len[s] - 1));
            end else if (roll < 85) begin
                at = q.size() + $urandom_range(0, sb.sig_len[s] - 1);
                append_sig(q, s, sb.sig_len[s]);
                q[at] = 8'($urandom_range(0, 255));
            end else begin
                q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic last, input bit fast);
        int gap;
        gap = draw_gap(fast);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_byte(data, last);
        items_sent++;
    endtask

    // Stops the input and waits until every expected beat has left, plus the
    // pipeline depth for bytes that produce nothing.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_reg(input logic [3:0] index, input logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.write_register(index, value);
    endtask

    task automatic set_config(input logic [3:0] cap, input logic [3:0] min_off,
                              input bit junk, input logic [3:0] junk_index,
                              input logic [3:0] junk_value);
        settle();
        push_reg(ess_pkg::REG_HIT_CAP, cap);
        push_reg(ess_pkg::REG_MIN_OFFSET, min_off);
        if (junk) push_reg(junk_index, junk_value);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_blob(input byte_q_t blob_bytes, input bit fast, input int split_at,
                             input logic [3:0] split_cap);
        for (int i = 0; i < blob_bytes.size(); i++) begin
            if (i == split_at) begin
                settle();
                push_reg(ess_pkg::REG_HIT_CAP, split_cap);
                cfg_valid <= 1'b0;
            end
            send_byte(blob_bytes[i], i == blob_bytes.size() - 1, fast);
        end
    endtask

    initial begin
        int           gap;
        scan_result_t got;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = draw_gap(rx_fast);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got.kind   = m_tuser;
            got.id     = m_tdata[4:0];
            got.offset = m_tdata[36:5];
            got.cap    = m_tdata[37];
            got.total  = m_tdata[45:38];
            got.last   = m_tlast;
            sb.check_beat(got);
        end
    end

    initial begin
        byte_q_t blob;
        int      target;
        int      split_at;
        bit      fast;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The zeroed window must not complete the wasm signature.
        blob = '{8'h61, 8'h73, 8'h6d};
        send_blob(blob, 1'b0, -1, 4'd0);
        // A hit at offset zero falls below the reset minimum offset.
        blob = '{8'h1f, 8'h8b, 8'h1f, 8'h8b};
        send_blob(blob, 1'b1, -1, 4'd0);
        blob = '{8'h00};
        send_blob(blob, 1'b0, -1, 4'd0);
        // With a cap of zero every hit is dropped.
        set_config(4'd0, 4'd0, 1'b1, REG_UNUSED_LAST, 4'hf);
        blob = '{8'h1f, 8'h8b, 8'hff, 8'hd8, 8'hff};
        send_blob(blob, 1'b1, -1, 4'd0);
        // Cap reached at two, then lowered to one in the middle of the blob.
        set_config(4'd2, 4'd0, 1'b1, REG_UNUSED_FIRST, 4'h5);
        blob = '{8'h1f, 8'h8b, 8'h1f, 8'h8b, 8'h1f, 8'h8b, 8'hff, 8'hd8, 8'hff};
        send_blob(blob, 1'b0, 4, 4'd1);

        // Every short signature fifteen times in one blob drives the total
        // into saturation; the long receiver hold backs the block up.
        set_config(4'd15, 4'd0, 1'b0, REG_UNUSED_FIRST, 4'h0);
        blob.delete();
        for (int r = 0; r < 15; r++)
            for (int s = 0; s < ess_pkg::NUM_SIGS; s++)
                if (sb.sig_len[s] <= 4) append_sig(blob, s, sb.sig_len[s]);
        blob.push_back(8'($urandom_range(0, 255)));
        hold_cycles = LONG_HOLD;
        send_blob(blob, 1'b1, -1, 4'd0);

        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 9) < 4)
                set_config(pick_setting(), pick_setting(), $urandom_range(0, 3) == 0,
                           4'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                           4'($urandom_range(0, 15)));
            target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                 : $urandom_range(1, 24);
            build_blob(blob, target, $urandom_range(0, 6) == 0);
            fast = ($urandom_range(0, 3) == 0);
            split_at = ($urandom_range(0, 9) == 0 && blob.size() > 1)
                       ? $urandom_range(1, blob.size() - 1) : -1;
            send_blob(blob, fast, split_at, 4'($urandom_range(0, 15)));
        end

        settle();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
